/* rtl/fixed_block_pool_allocator_core_assert.svh */
// Assertion macros for the fixed block pool allocator checker.
// Depends on nothing; included by the checker file only.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fbpa_pkg.sv */
// Shared types, codes and constants of the fixed block pool allocator.
// No dependencies; imported by fbpa_div, the allocator core and the checker.
`default_nettype none

package fbpa_pkg;

  localparam int ADDR_W         = 32;
  localparam int REQ_W          = 16;
  localparam int BLK_W          = 17;
  localparam int FB_W           = 11;
  localparam int KIND_W         = 2;
  localparam int STAT_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int POINTER_BYTES  = 4;

  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 2'd3;

  localparam logic [REQ_W-1:0] CFG_BLOCK_RST = 16'd4;
  localparam logic [REQ_W-1:0] CFG_ALIGN_RST = 16'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted_address;
    logic [FB_W-1:0]   free_blocks;
    logic [FB_W-1:0]   pool_capacity;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [BLK_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/fbpa_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; holds the free-address stack of the allocator.
`default_nettype none

module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/fbpa_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on fbpa_pkg; the quotient must fit in QB bits.
`default_nettype none

module fbpa_div import fbpa_pkg::*; #(
  parameter int QB = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire div_req_t      req,
  output div_rsp_t           rsp,
  output logic [QB-1:0]      quotient
);

  localparam int SH_W  = BLK_W + QB - 1;
  localparam int CW    = (ADDR_W > SH_W) ? ADDR_W : SH_W;
  localparam int CNT_W = (QB > 1) ? $clog2(QB) : 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] rem_r, rem_nxt;
  logic [SH_W-1:0]   dvs_r, dvs_nxt;
  logic [QB-1:0]     q_r, q_nxt;
  logic              fit;

  always_comb begin
    fit      = CW'(rem_r) >= CW'(dvs_r);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = req.dividend;
      dvs_nxt  = SH_W'(req.divisor) << (QB - 1);
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(QB - 1);
    end else if (busy_r) begin
      if (fit) begin
        rem_nxt = rem_r - ADDR_W'(dvs_r);
      end
      q_nxt   = (q_r << 1) | QB'(fit);
      dvs_nxt = dvs_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;
  assign quotient      = q_r;

endmodule

`default_nettype wire

/* rtl/fixed_block_pool_allocator_core.sv */
// Fixed block pool allocator: LIFO free-address stack in a registered-read RAM.
// Alloc reads the top of the stack and registers the granted address in S_ALLOC_RD; an empty
// pool fails from idle without a read. Free checks block alignment with the bit-serial divider.
// Init computes padding and capacity, divides unless the capacity saturates, then fills the RAM.
// Items are taken one at a time; each is accepted the cycle after its predecessor's result
// is registered. Reset clears control state and loads register defaults, not the RAM.
`default_nettype none

module fixed_block_pool_allocator_core import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int DW    = $clog2(MAX_BLOCKS + 1);
  localparam int MUL_W = BLK_W + DW;
  localparam int CMP_W = (ADDR_W > MUL_W) ? ADDR_W : MUL_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ALLOC_RD = 4'd1;
  localparam logic [3:0] S_FREE_CHK = 4'd2;
  localparam logic [3:0] S_FREE_DIV = 4'd3;
  localparam logic [3:0] S_INIT_PAD = 4'd4;
  localparam logic [3:0] S_INIT_CHK = 4'd5;
  localparam logic [3:0] S_INIT_DIV = 4'd6;
  localparam logic [3:0] S_FILL     = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] cfg_base_r, cfg_bytes_r;
  logic [REQ_W-1:0]  cfg_block_r, cfg_align_r;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic [DW-1:0]     cap_r, cap_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [ADDR_W-1:0] span_r, span_nxt;
  logic [BLK_W-1:0]  ebb_r, ebb_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [BLK_W-1:0]  init_blk_r, init_blk_nxt;
  logic [ADDR_W-1:0] init_start_r, init_start_nxt;
  logic              init_bad_r, init_bad_nxt;
  logic [ADDR_W-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0]     fill_idx_r, fill_idx_nxt;
  logic [ADDR_W-1:0] acc_r, acc_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_granted_r, res_granted_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [REQ_W-1:0]  align_eff, blk_raw;
  logic [BLK_W-1:0]  align_m1, blk_round;
  logic [ADDR_W-1:0] start_calc, pad;
  logic              bad_calc;
  logic [DW-1:0]     depth_m1;
  logic [MUL_W-1:0]  sat_lim;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ADDR_W-1:0] ram_wdata, ram_rdata;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [AW-1:0]     div_quot;

  logic              fin, commit, out_free;
  logic [STAT_W-1:0] fin_status;
  logic [ADDR_W-1:0] fin_granted;
  logic [DW-1:0]     commit_cap;

  fbpa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_BLOCKS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fbpa_div #(
    .QB (AW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .rsp      (div_rsp),
    .quotient (div_quot)
  );

  always_comb begin
    align_eff  = (cfg_align_r < REQ_W'(POINTER_BYTES)) ? REQ_W'(POINTER_BYTES) : cfg_align_r;
    blk_raw    = (cfg_block_r < REQ_W'(POINTER_BYTES)) ? REQ_W'(POINTER_BYTES) : cfg_block_r;
    align_m1   = BLK_W'(align_eff) - BLK_W'(1);
    blk_round  = (BLK_W'(blk_raw) + align_m1) & ~align_m1;
    start_calc = (cfg_base_r + ADDR_W'(align_m1)) & ~ADDR_W'(align_m1);
    bad_calc   = (cfg_base_r == '0) || (cfg_align_r == '0) ||
                 ((cfg_align_r & (cfg_align_r - REQ_W'(1))) != '0);
    pad        = init_start_r - cfg_base_r;
    depth_m1   = depth_r - DW'(1);
    sat_lim    = MUL_W'(init_blk_r) * MUL_W'(MAX_BLOCKS);
    out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    state_nxt       = state_r;
    depth_nxt       = depth_r;
    cap_nxt         = cap_r;
    start_nxt       = start_r;
    span_nxt        = span_r;
    ebb_nxt         = ebb_r;
    addr_nxt        = addr_r;
    init_blk_nxt    = init_blk_r;
    init_start_nxt  = init_start_r;
    init_bad_nxt    = init_bad_r;
    dvd_nxt         = dvd_r;
    fill_idx_nxt    = fill_idx_r;
    acc_nxt         = acc_r;
    res_status_nxt  = res_status_r;
    res_granted_nxt = res_granted_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_item_nxt    = out_item_r;
    ram_we          = 1'b0;
    ram_waddr       = fill_idx_r[AW-1:0];
    ram_wdata       = init_start_r + acc_r;
    ram_re          = 1'b0;
    ram_raddr       = depth_m1[AW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = dvd_r;
    div_req.divisor  = (state_r == S_INIT_CHK) ? init_blk_r : ebb_r;
    fin             = 1'b0;
    fin_status      = ST_INVALID;
    fin_granted     = '0;
    commit          = 1'b0;
    commit_cap      = DW'(MAX_BLOCKS);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          addr_nxt = in_item.block_address;
          case (in_item.kind)
            KIND_INIT: begin
              init_blk_nxt   = blk_round;
              init_start_nxt = start_calc;
              init_bad_nxt   = bad_calc;
              state_nxt      = S_INIT_PAD;
            end
            KIND_ALLOC: begin
              if (depth_r == '0) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                depth_nxt = depth_m1;
                state_nxt = S_ALLOC_RD;
              end
            end
            KIND_FREE: begin
              if (in_item.block_address == '0) begin
                fin = 1'b1;
              end else begin
                dvd_nxt   = in_item.block_address - start_r;
                state_nxt = S_FREE_CHK;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        fin         = 1'b1;
        fin_status  = ST_OK;
        fin_granted = ram_rdata;
      end
      S_FREE_CHK: begin
        if ((dvd_r >= span_r) || (ebb_r == '0)) begin
          fin = 1'b1;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_FREE_DIV;
        end
      end
      S_FREE_DIV: begin
        if (div_rsp.done) begin
          fin = 1'b1;
          if (div_rsp.remainder != '0) begin
            fin_status = ST_INVALID;
          end else if (depth_r >= DW'(MAX_BLOCKS)) begin
            fin_status = ST_FULL;
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = depth_r[AW-1:0];
            ram_wdata  = addr_r;
            depth_nxt  = depth_r + DW'(1);
            fin_status = ST_OK;
          end
        end
      end
      S_INIT_PAD: begin
        if (init_bad_r || (cfg_bytes_r <= pad)) begin
          fin = 1'b1;
        end else begin
          dvd_nxt   = cfg_bytes_r - pad;
          state_nxt = S_INIT_CHK;
        end
      end
      S_INIT_CHK: begin
        if (CMP_W'(dvd_r) >= CMP_W'(sat_lim)) begin
          commit     = 1'b1;
          commit_cap = DW'(MAX_BLOCKS);
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_INIT_DIV;
        end
      end
      S_INIT_DIV: begin
        if (div_rsp.done) begin
          if (div_quot == '0) begin
            fin = 1'b1;
          end else begin
            commit     = 1'b1;
            commit_cap = DW'(div_quot);
          end
        end
      end
      S_FILL: begin
        ram_we       = 1'b1;
        acc_nxt      = acc_r + ADDR_W'(ebb_r);
        fill_idx_nxt = fill_idx_r + DW'(1);
        if (fill_idx_nxt == cap_r) begin
          depth_nxt  = cap_r;
          span_nxt   = acc_nxt;
          fin        = 1'b1;
          fin_status = ST_OK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_item_nxt.status          = res_status_r;
          out_item_nxt.granted_address = res_granted_r;
          out_item_nxt.free_blocks     = FB_W'(depth_r);
          out_item_nxt.pool_capacity   = FB_W'(cap_r);
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (commit) begin
      start_nxt    = init_start_r;
      ebb_nxt      = init_blk_r;
      cap_nxt      = commit_cap;
      fill_idx_nxt = '0;
      acc_nxt      = '0;
      state_nxt    = S_FILL;
    end

    if (fin) begin
      if (out_free) begin
        out_valid_nxt                = 1'b1;
        out_item_nxt.status          = fin_status;
        out_item_nxt.granted_address = fin_granted;
        out_item_nxt.free_blocks     = FB_W'(depth_nxt);
        out_item_nxt.pool_capacity   = FB_W'(cap_nxt);
        state_nxt                    = S_IDLE;
      end else begin
        res_status_nxt  = fin_status;
        res_granted_nxt = fin_granted;
        state_nxt       = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      cap_r       <= '0;
      start_r     <= '0;
      span_r      <= '0;
      ebb_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_base_r  <= '0;
      cfg_bytes_r <= '0;
      cfg_block_r <= CFG_BLOCK_RST;
      cfg_align_r <= CFG_ALIGN_RST;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      cap_r       <= cap_nxt;
      start_r     <= start_nxt;
      span_r      <= span_nxt;
      ebb_r       <= ebb_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE:  cfg_base_r  <= cfg_data[ADDR_W-1:0];
          CFG_BYTES: cfg_bytes_r <= cfg_data[ADDR_W-1:0];
          CFG_BLOCK: cfg_block_r <= cfg_data[REQ_W-1:0];
          CFG_ALIGN: cfg_align_r <= cfg_data[REQ_W-1:0];
          default: begin
          end
        endcase
      end
    end
    addr_r        <= addr_nxt;
    init_blk_r    <= init_blk_nxt;
    init_start_r  <= init_start_nxt;
    init_bad_r    <= init_bad_nxt;
    dvd_r         <= dvd_nxt;
    fill_idx_r    <= fill_idx_nxt;
    acc_r         <= acc_nxt;
    res_status_r  <= res_status_nxt;
    res_granted_r <= res_granted_nxt;
    out_item_r    <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

/* rtl/fbpa_chk.sv */
// Port-level checker for the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_core_assert.svh.
`default_nettype none

`include "fixed_block_pool_allocator_core_assert.svh"

module fbpa_chk import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // A stalled result stays put.
  `FBPA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled result item changed")

  // A stalled input item stays put until it is taken.
  `FBPA_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_item), "stalled input item changed")

  `FBPA_ASSERT_IMP(a_grant_only_ok, clk, rst_n, out_valid && (out_item.status != ST_OK), out_item.granted_address == '0, "address granted on a failed item")

  `FBPA_ASSERT_IMP(a_empty_depth, clk, rst_n, out_valid && (out_item.status == ST_EMPTY), out_item.free_blocks == '0, "empty status with free blocks left")

  `FBPA_ASSERT_IMP(a_full_depth, clk, rst_n, out_valid && (out_item.status == ST_FULL), out_item.free_blocks == FB_W'(MAX_BLOCKS), "full status with stack not full")

endmodule

bind fixed_block_pool_allocator_core fbpa_chk #(
  .MAX_BLOCKS (MAX_BLOCKS)
) u_fbpa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for fixed_block_pool_allocator_core: init, alloc and free items
// are predicted by an in-bench model of the LIFO free-address stack and checked per field.
// Depends on fbpa_pkg and the fixed_block_pool_allocator_core RTL.
module tb;
  import fbpa_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam logic [63:0] ADDR_MASK = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [ADDR_W-1:0] base_reg = '0;
  logic [ADDR_W-1:0] bytes_reg = '0;
  logic [REQ_W-1:0] block_reg = CFG_BLOCK_RST;
  logic [REQ_W-1:0] align_reg = CFG_ALIGN_RST;
  logic [ADDR_W-1:0] free_addrs [DEF_MAX_BLOCKS];
  int unsigned depth = 0;
  int unsigned capacity = 0;
  logic [63:0] pool_start = '0;
  logic [63:0] pool_span = '0;
  logic [63:0] pool_blk = '0;

  in_item_t pending_items[$];
  out_item_t replies_due[$];
  int faults = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit steady = 1'b0;

  fixed_block_pool_allocator_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned idle_draw();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic out_item_t pool_reply(in_item_t it);
    out_item_t r;
    logic [63:0] al, blk, start, pad, cap, off;
    bit ok;
    r = '0;
    r.status = ST_INVALID;
    case (it.kind)
      KIND_INIT: begin
        ok = base_reg != 0 && align_reg != 0 && (align_reg & (align_reg - 16'd1)) == 16'd0;
        al = (align_reg < POINTER_BYTES) ? POINTER_BYTES : align_reg;
        blk = (block_reg < POINTER_BYTES) ? POINTER_BYTES : block_reg;
        blk = (blk + al - 1) & ~(al - 1);
        start = ((base_reg + al - 1) & ~(al - 1)) & ADDR_MASK;
        pad = (start - base_reg) & ADDR_MASK;
        ok = ok && bytes_reg > pad;
        cap = ok ? (bytes_reg - pad) / blk : 0;
        if (ok && cap != 0) begin
          if (cap > DEF_MAX_BLOCKS) cap = DEF_MAX_BLOCKS;
          pool_start = start;
          pool_span = cap * blk;
          pool_blk = blk;
          capacity = 32'(cap);
          for (int i = 0; i < cap; i++) free_addrs[i] = ADDR_W'(start + i * blk);
          depth = 32'(cap);
          r.status = ST_OK;
        end
      end
      KIND_ALLOC: begin
        if (depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          depth--;
          r.granted_address = free_addrs[depth];
          r.status = ST_OK;
        end
      end
      KIND_FREE: begin
        off = (it.block_address - pool_start) & ADDR_MASK;
        if (it.block_address == 0 || off >= pool_span || pool_blk == 0 || off % pool_blk != 0)
          r.status = ST_INVALID;
        else if (depth >= DEF_MAX_BLOCKS)
          r.status = ST_FULL;
        else begin
          free_addrs[depth] = it.block_address;
          depth++;
          r.status = ST_OK;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    r.free_blocks = FB_W'(depth);
    r.pool_capacity = FB_W'(capacity);
    return r;
  endfunction

  always @(posedge clk) begin : feed
    logic vld;
    in_item_t nxt;
    vld = in_valid;
    nxt = in_item;
    if (!rst_n) begin
      vld = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        replies_due.push_back(pool_reply(in_item));
        vld = 1'b0;
        gap_left = idle_draw();
      end
      if (!vld) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          vld = 1'b1;
        end
      end
    end
    in_valid <= vld;
    in_item <= nxt;
  end

  always @(posedge clk) begin : observe
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        stall_left = idle_draw();
        if (replies_due.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected result: status %0d addr %h free %0d cap %0d",
                     out_item.status, out_item.granted_address, out_item.free_blocks,
                     out_item.pool_capacity);
        end else begin
          want = replies_due.pop_front();
          if (want.status !== out_item.status ||
              want.granted_address !== out_item.granted_address ||
              want.free_blocks !== out_item.free_blocks ||
              want.pool_capacity !== out_item.pool_capacity) begin
            faults++;
            if (faults <= 10)
              $display({"mismatch: expected status %0d addr %h free %0d cap %0d,",
                        " got status %0d addr %h free %0d cap %0d"},
                       want.status, want.granted_address, want.free_blocks,
                       want.pool_capacity, out_item.status, out_item.granted_address,
                       out_item.free_blocks, out_item.pool_capacity);
          end
        end
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || replies_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] base, bytes, blk, al);
    wait_idle();
    write_reg(CFG_BASE, base);
    write_reg(CFG_BYTES, bytes);
    write_reg(CFG_BLOCK, blk);
    write_reg(CFG_ALIGN, al);
    @(posedge clk);
    cfg_we <= 1'b0;
    base_reg = base;
    bytes_reg = bytes;
    block_reg = blk[REQ_W-1:0];
    align_reg = al[REQ_W-1:0];
  endtask

  task automatic queue_item(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a);
    pending_items.push_back({k, a});
  endtask

  initial begin : stimulus
    int unsigned sent, n, pick, mode;
    logic [31:0] al, blk, unit, a4, base;
    logic [63:0] slot;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Before any good init: empty pool, every free rejected, null base rejected.
    queue_item(KIND_ALLOC, 32'h0);
    queue_item(KIND_FREE, 32'h0000_0040);
    queue_item(KIND_FREE, 32'h0);
    queue_item(KIND_INIT, 32'h0);
    queue_item(KIND_NOP, 32'hFFFF_FFFF);

    // Unaligned base and odd block size: eleven blocks of eight bytes.
    set_config(32'h1000_0003, 32'd100, 32'd5, 32'd8);
    queue_item(KIND_INIT, 32'h0);
    queue_item(KIND_ALLOC, 32'h0);
    queue_item(KIND_FREE, 32'h1000_000C);
    queue_item(KIND_FREE, 32'h1000_0000);
    queue_item(KIND_FREE, 32'h1000_0060);
    queue_item(KIND_FREE, 32'h1000_0058);
    queue_item(KIND_ALLOC, 32'h0);
    queue_item(KIND_ALLOC, 32'h0);

    set_config(32'h1000_0003, 32'd100, 32'd5, 32'd12);
    queue_item(KIND_INIT, 32'h0);
    set_config(32'h1000_0003, 32'd100, 32'd5, 32'd0);
    queue_item(KIND_INIT, 32'h0);

    // The aligned start wraps to zero; the buffer first only covers the padding,
    // then is too short for one block, then holds a pool that starts at address zero.
    set_config(32'hFFFF_FFFD, 32'd3, 32'd0, 32'd1);
    queue_item(KIND_INIT, 32'h0);
    set_config(32'hFFFF_FFFD, 32'd4, 32'd0, 32'd1);
    queue_item(KIND_INIT, 32'h0);
    set_config(32'hFFFF_FFFD, 32'd100, 32'd0, 32'd1);
    queue_item(KIND_INIT, 32'h0);
    queue_item(KIND_FREE, 32'h0);
    queue_item(KIND_FREE, 32'h0000_0004);
    queue_item(KIND_ALLOC, 32'h0);

    // Largest block and alignment; capacity saturates and the stack is full.
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_8000);
    queue_item(KIND_INIT, 32'h0);
    queue_item(KIND_FREE, 32'h0001_0000);
    queue_item(KIND_FREE, 32'hFFFF_FFFF);
    queue_item(KIND_ALLOC, 32'h0);

    sent = 0;
    while (sent < 950) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        set_config($urandom, $urandom, $urandom, $urandom);
      end else if (mode == 1) begin
        al = ($urandom & 32'hFFFF_0000) | (32'd1 << $urandom_range(0, 15));
        set_config($urandom, $urandom, $urandom, al);
      end else begin
        al = 32'd1 << $urandom_range(0, 6);
        blk = $urandom_range(0, 48);
        a4 = (al < 4) ? 4 : al;
        unit = (blk < 4) ? 4 : blk;
        unit = ((unit + a4 - 1) / a4) * a4;
        base = ($urandom_range(0, 7) == 0) ? (32'hFFFF_FF00 | $urandom_range(0, 255))
                                            : $urandom;
        set_config(base, $urandom_range(0, 40) * unit + $urandom_range(0, a4), blk, al);
      end
      steady = ($urandom_range(0, 3) == 0);
      queue_item(KIND_INIT, $urandom);
      wait_idle();
      n = $urandom_range(20, 60);
      for (int j = 0; j < n; j++) begin
        pick = $urandom_range(0, 99);
        slot = pool_start + $urandom_range(0, capacity > 0 ? capacity - 1 : 0) * pool_blk;
        if (pick < 45)
          queue_item(KIND_ALLOC, $urandom);
        else if (pick < 80)
          queue_item(KIND_FREE, ADDR_W'(slot));
        else if (pick < 86)
          queue_item(KIND_FREE,
                     ADDR_W'(slot + $urandom_range(1, pool_blk > 1 ? pool_blk - 1 : 1)));
        else if (pick < 92)
          queue_item(KIND_FREE, $urandom);
        else if (pick < 95)
          queue_item(KIND_INIT, $urandom);
        else if (pick < 97)
          queue_item(KIND_NOP, $urandom);
        else
          queue_item(KIND_FREE, $urandom_range(0, 1) ? ADDR_W'(pool_start - pool_blk)
                                                      : ADDR_W'(pool_start + pool_span));
      end
      sent += n + 1;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (replies_due.size() != 0) faults++;
    if (faults == 0) begin
      $display("fixed_block_pool_allocator_core regression: pass");
    end else begin
      $display("fixed_block_pool_allocator_core regression: fail");
    end
    $finish;
  end

  initial begin
    #24000000;
    $display("fixed_block_pool_allocator_core regression: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_ram.sv
rtl/fbpa_div.sv
rtl/fixed_block_pool_allocator_core.sv
rtl/fbpa_chk.sv
tb/sv/tb.sv
